### rtl/psc_pkg.sv
package psc_pkg;

  localparam int unsigned NumElem = 16;
  localparam int unsigned IdxW    = 5;

  typedef enum logic [1:0] {
    AggEqAny   = 2'd0,
    AggRanges  = 2'd1,
    AggEqEach  = 2'd2,
    AggEqOrder = 2'd3
  } agg_e;

  typedef enum logic [1:0] {
    PolPlain    = 2'd0,
    PolNegAll   = 2'd1,
    PolPlain2   = 2'd2,
    PolNegValid = 2'd3
  } pol_e;

  // Decoded immediate carried down the pipe
  typedef struct packed {
    logic       idx_cmd;
    logic       words;
    agg_e       agg;
    pol_e       pol;
    logic       sel;
  } ctl_t;

  // Saturated length of one operand, element count n (8 or 16)
  function automatic logic [4:0] sat_len(input logic [63:0] v, input logic wide,
                                         input logic words);
    logic [63:0] x;
    logic [63:0] mag;
    logic [4:0]  n;
    begin
      n = words ? 5'd8 : 5'd16;
      x = wide ? v : {{32{v[31]}}, v[31:0]};
      mag = x[63] ? (~x + 64'd1) : x;
      if (x[63] && x[62:0] == '0) begin
        sat_len = n;
      end else if (mag > {59'd0, n}) begin
        sat_len = n;
      end else begin
        sat_len = mag[4:0];
      end
    end
  endfunction

endpackage

### rtl/packed_string_compare.sv
// Channel | Dir | Handshake                      | Payload
// in      | in  | in_valid_i / in_ready_o        | cmd, control, a/b halves, lengths
// out     | out | out_valid_o / out_ready_i      | mask halves, match_index, flags
//
// Four register stages: compare matrix and lengths, aggregation, polarity,
// output formatting. One word enters per cycle while in_ready_o is high.
// A stall holds every full stage whose successor is held too; bubbles close up.
// Reset clears the stage valid bits only.
module packed_string_compare (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  control_i,
  input  logic [63:0] a_lo_i,
  input  logic [63:0] a_hi_i,
  input  logic [63:0] b_lo_i,
  input  logic [63:0] b_hi_i,
  input  logic signed [63:0] len_a_i,
  input  logic signed [63:0] len_b_i,
  input  logic        wide_lengths_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] mask_lo_o,
  output logic [63:0] mask_hi_o,
  output logic [4:0]  match_index_o,
  output logic        flag_carry_o,
  output logic        flag_zero_o,
  output logic        flag_sign_o,
  output logic        flag_overflow_o
);

  localparam int unsigned N = psc_pkg::NumElem;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // ---------------- stage 1: element compares, lengths
  psc_pkg::ctl_t ctl_d;
  logic [N-1:0][N-1:0] eq_d, le_d, ge_d;
  logic [4:0] la_d, lb_d;
  logic [N-1:0][16:0] av, bv;
  logic [N-1:0] az, bz;
  logic [4:0] nz_a, nz_b;
  logic [127:0] a_all, b_all;

  assign a_all = {a_hi_i, a_lo_i};
  assign b_all = {b_hi_i, b_lo_i};

  always_comb begin
    ctl_d.idx_cmd = cmd_i[0];
    ctl_d.words   = control_i[0];
    ctl_d.agg     = psc_pkg::agg_e'(control_i[3:2]);
    ctl_d.pol     = psc_pkg::pol_e'(control_i[5:4]);
    ctl_d.sel     = control_i[6];
    for (int i = 0; i < N; i++) begin
      if (control_i[0]) begin
        if (i < 8) begin
          av[i] = {control_i[1] & a_all[16*(i%8)+15], a_all[16*(i%8) +: 16]};
          bv[i] = {control_i[1] & b_all[16*(i%8)+15], b_all[16*(i%8) +: 16]};
        end else begin
          av[i] = '0;
          bv[i] = '0;
        end
      end else begin
        av[i] = {{9{control_i[1] & a_all[8*i+7]}}, a_all[8*i +: 8]};
        bv[i] = {{9{control_i[1] & b_all[8*i+7]}}, b_all[8*i +: 8]};
      end
      az[i] = (av[i] == '0);
      bz[i] = (bv[i] == '0);
    end
    for (int j = 0; j < N; j++) begin
      for (int i = 0; i < N; i++) begin
        eq_d[j][i] = (av[i] == bv[j]);
        le_d[j][i] = ($signed(av[i]) <= $signed(bv[j]));
        ge_d[j][i] = ($signed(av[i]) >= $signed(bv[j]));
      end
    end
    nz_a = control_i[0] ? 5'd8 : 5'd16;
    nz_b = nz_a;
    for (int i = N - 1; i >= 0; i--) begin
      if (az[i] && (!control_i[0] || i < 8)) nz_a = 5'(i);
      if (bz[i] && (!control_i[0] || i < 8)) nz_b = 5'(i);
    end
    if (cmd_i[1]) begin
      la_d = nz_a;
      lb_d = nz_b;
    end else begin
      la_d = psc_pkg::sat_len(len_a_i, wide_lengths_i, control_i[0]);
      lb_d = psc_pkg::sat_len(len_b_i, wide_lengths_i, control_i[0]);
    end
  end

  psc_pkg::ctl_t ctl1_q;
  logic [N-1:0][N-1:0] cm1_q;
  logic [4:0] la1_q, lb1_q;
  logic [N-1:0][N-1:0] cm_d;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      for (int i = 0; i < N; i++) begin
        if (ctl_d.agg == psc_pkg::AggRanges) begin
          cm_d[j][i] = (i % 2 == 1) ? ge_d[j][i] : le_d[j][i];
        end else begin
          cm_d[j][i] = eq_d[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      ctl1_q <= ctl_d;
      cm1_q  <= cm_d;
      la1_q  <= la_d;
      lb1_q  <= lb_d;
    end
  end

  // ---------------- stage 2: forced compares and aggregation
  logic [N-1:0] n_mask;
  logic [N-1:0] va, vb;
  logic [N-1:0][N-1:0] f;
  logic [N-1:0] res_d;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      n_mask[i] = !ctl1_q.words || i < 8;
      va[i] = (5'(i) < la1_q);
      vb[i] = (5'(i) < lb1_q);
    end
    for (int j = 0; j < N; j++) begin
      for (int i = 0; i < N; i++) begin
        unique case (ctl1_q.agg)
          psc_pkg::AggEqAny, psc_pkg::AggRanges: f[j][i] = va[i] && vb[j] && cm1_q[j][i];
          psc_pkg::AggEqEach: f[j][i] = (va[i] && vb[j]) ? cm1_q[j][i] : (!va[i] && !vb[j]);
          default: f[j][i] = !va[i] ? 1'b1 : (!vb[j] ? 1'b0 : cm1_q[j][i]);
        endcase
      end
    end
    for (int j = 0; j < N; j++) begin
      res_d[j] = 1'b0;
      unique case (ctl1_q.agg)
        psc_pkg::AggEqAny: begin
          for (int i = 0; i < N; i++) res_d[j] |= f[j][i] && n_mask[i];
        end
        psc_pkg::AggRanges: begin
          for (int i = 0; i < N; i += 2) res_d[j] |= f[j][i] && f[j][i+1] && n_mask[i+1];
        end
        psc_pkg::AggEqEach: res_d[j] = f[j][j];
        default: begin
          res_d[j] = 1'b1;
          for (int i = 0; i < N; i++) begin
            if (i + j < N && n_mask[i + j]) res_d[j] &= f[(i + j) % N][i];
          end
        end
      endcase
      res_d[j] &= n_mask[j];
    end
  end

  psc_pkg::ctl_t ctl2_q;
  logic [N-1:0] res2_q;
  logic [4:0] la2_q, lb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      ctl2_q <= ctl1_q;
      res2_q <= res_d;
      la2_q  <= la1_q;
      lb2_q  <= lb1_q;
    end
  end

  // ---------------- stage 3: polarity and flags
  logic [N-1:0] pol_d;
  logic [4:0] n2;
  always_comb begin
    n2 = ctl2_q.words ? 5'd8 : 5'd16;
    pol_d = res2_q;
    for (int j = 0; j < N; j++) begin
      case (ctl2_q.pol)
        psc_pkg::PolNegAll:   if (5'(j) < n2) pol_d[j] = !res2_q[j];
        psc_pkg::PolNegValid: if (5'(j) < lb2_q) pol_d[j] = !res2_q[j];
        default: ;
      endcase
    end
  end

  psc_pkg::ctl_t ctl3_q;
  logic [N-1:0] res3_q;
  logic fz3_q, fs3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      ctl3_q <= ctl2_q;
      res3_q <= pol_d;
      fz3_q  <= (lb2_q < n2);
      fs3_q  <= (la2_q < n2);
    end
  end

  // ---------------- stage 4: mask expansion or index search
  logic [63:0] mlo_d, mhi_d;
  logic [4:0] idx_d;
  always_comb begin
    mlo_d = '0;
    mhi_d = '0;
    idx_d = '0;
    if (ctl3_q.idx_cmd) begin
      idx_d = ctl3_q.words ? 5'd8 : 5'd16;
      if (ctl3_q.sel) begin
        for (int j = 0; j < N; j++) if (res3_q[j]) idx_d = 5'(j);
      end else begin
        for (int j = N - 1; j >= 0; j--) if (res3_q[j]) idx_d = 5'(j);
      end
    end else if (ctl3_q.sel) begin
      for (int j = 0; j < 8; j++) begin
        if (ctl3_q.words) begin
          if (j < 4) mlo_d[16*j +: 16] = {16{res3_q[j]}};
          else mhi_d[16*(j-4) +: 16] = {16{res3_q[j]}};
        end
      end
      if (!ctl3_q.words) begin
        for (int j = 0; j < 8; j++) begin
          mlo_d[8*j +: 8] = {8{res3_q[j]}};
          mhi_d[8*j +: 8] = {8{res3_q[j+8]}};
        end
      end
    end else begin
      mlo_d = {48'd0, res3_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      mask_lo_o       <= mlo_d;
      mask_hi_o       <= mhi_d;
      match_index_o   <= idx_d;
      flag_carry_o    <= (res3_q != '0);
      flag_zero_o     <= fz3_q;
      flag_sign_o     <= fs3_q;
      flag_overflow_o <= res3_q[0];
    end
  end

  assign out_valid_o = v4_q;

endmodule

### rtl/psc_checker.sv
module psc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [63:0] mask_lo_o,
  input logic [63:0] mask_hi_o,
  input logic [4:0] match_index_o,
  input logic       flag_carry_o,
  input logic       flag_overflow_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mask_lo_o))
    else $error("result word dropped under stall");

  a_ready_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_index_o <= 5'd16)
    else $error("index out of range");

  a_of_cf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flag_overflow_o |-> flag_carry_o)
    else $error("overflow flag without carry");

  a_idx_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_index_o != 5'd0 |-> mask_lo_o == '0 && mask_hi_o == '0)
    else $error("index and mask both nonzero");

endmodule

bind packed_string_compare psc_checker u_psc_checker (.*);

### tb/tb_packed_string_compare.sv
`timescale 1ns / 1ps

module tb_packed_string_compare;

  localparam logic [1:0] CmdExpMask = 2'd0;
  localparam logic [1:0] CmdExpIdx  = 2'd1;
  localparam logic [1:0] CmdImpMask = 2'd2;
  localparam logic [1:0] CmdImpIdx  = 2'd3;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  control;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
    logic [63:0] len_a;
    logic [63:0] len_b;
    logic        wide;
  } op_t;

  typedef struct packed {
    logic [63:0] mask_lo;
    logic [63:0] mask_hi;
    logic [4:0]  match_index;
    logic        cf;
    logic        zf;
    logic        sf;
    logic        of;
  } cmp_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0]  cmd_i;
  logic [6:0]  control_i;
  logic [63:0] a_lo_i, a_hi_i, b_lo_i, b_hi_i;
  logic signed [63:0] len_a_i, len_b_i;
  logic        wide_lengths_i;
  logic [63:0] mask_lo_o, mask_hi_o;
  logic [4:0]  match_index_o;
  logic flag_carry_o, flag_zero_o, flag_sign_o, flag_overflow_o;

  cmp_res_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit hold_off;
  bit done;

  packed_string_compare DUT (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] elem(logic [63:0] lo, logic [63:0] hi, int idx,
                                       logic words);
    logic [127:0] v;
    v = {hi, lo};
    return words ? v[16*idx +: 16] : {8'd0, v[8*idx +: 8]};
  endfunction

  function automatic int signed elem_val(logic [15:0] x, logic words, logic sgn);
    if (!sgn) return int'(x);
    return words ? int'($signed(x)) : int'($signed(x[7:0]));
  endfunction

  function automatic int clamp_len(logic [63:0] v, logic wide, int n);
    logic [63:0] x;
    logic [63:0] mag;
    x = wide ? v : {{32{v[31]}}, v[31:0]};
    mag = x[63] ? (~x + 64'd1) : x;
    if (x == 64'h8000_0000_0000_0000) return n;
    return (mag > n) ? n : int'(mag);
  endfunction

  function automatic bit pin_invalid(bit v, bit ia, bit jb, psc_pkg::agg_e agg);
    case (agg)
      psc_pkg::AggEqAny, psc_pkg::AggRanges: return ia && jb && v;
      psc_pkg::AggEqEach: return (!ia || !jb) ? (!ia && !jb) : v;
      default: return !ia ? 1'b1 : (!jb ? 1'b0 : v);
    endcase
  endfunction

  function automatic cmp_res_t predict_result(op_t op);
    cmp_res_t r;
    logic words, sgn, sel;
    psc_pkg::agg_e agg;
    psc_pkg::pol_e pol;
    int n, la, lb;
    int signed av[16];
    int signed bv[16];
    bit cm[16][16];
    logic [15:0] res;
    logic [127:0] m;
    bit acc;
    words = op.control[0];
    sgn = op.control[1];
    agg = psc_pkg::agg_e'(op.control[3:2]);
    pol = psc_pkg::pol_e'(op.control[5:4]);
    sel = op.control[6];
    n = words ? 8 : 16;
    r = '0;
    res = '0;
    m = '0;
    for (int i = 0; i < n; i++) begin
      av[i] = elem_val(elem(op.a_lo, op.a_hi, i, words), words, sgn);
      bv[i] = elem_val(elem(op.b_lo, op.b_hi, i, words), words, sgn);
    end
    for (int j = 0; j < n; j++)
      for (int i = 0; i < n; i++)
        cm[j][i] = (agg == psc_pkg::AggRanges) ?
                   ((i % 2) ? (av[i] >= bv[j]) : (av[i] <= bv[j])) : (av[i] == bv[j]);
    if (op.cmd[1]) begin
      la = n;
      lb = n;
      for (int i = n - 1; i >= 0; i--) begin
        if (av[i] == 0) la = i;
        if (bv[i] == 0) lb = i;
      end
    end else begin
      la = clamp_len(op.len_a, op.wide, n);
      lb = clamp_len(op.len_b, op.wide, n);
    end
    for (int j = 0; j < n; j++) begin
      acc = 1'b0;
      case (agg)
        psc_pkg::AggEqAny:
          for (int i = 0; i < n; i++) acc |= pin_invalid(cm[j][i], i < la, j < lb, agg);
        psc_pkg::AggRanges:
          for (int i = 0; i < n; i += 2)
            acc |= pin_invalid(cm[j][i], i < la, j < lb, agg) &&
                   pin_invalid(cm[j][i+1], i + 1 < la, j < lb, agg);
        psc_pkg::AggEqEach: acc = pin_invalid(cm[j][j], j < la, j < lb, agg);
        default: begin
          acc = 1'b1;
          for (int k = j; k < n; k++)
            acc &= pin_invalid(cm[k][k-j], (k - j) < la, k < lb, agg);
        end
      endcase
      res[j] = acc;
    end
    if (pol == psc_pkg::PolNegAll) res ^= words ? 16'h00FF : 16'hFFFF;
    else if (pol == psc_pkg::PolNegValid)
      for (int j = 0; j < lb; j++) res[j] = ~res[j];
    if (op.cmd[0]) begin
      r.match_index = 5'(n);
      if (sel) begin
        for (int j = 0; j < n; j++) if (res[j]) r.match_index = 5'(j);
      end else begin
        for (int j = n - 1; j >= 0; j--) if (res[j]) r.match_index = 5'(j);
      end
    end else if (sel) begin
      for (int j = 0; j < n; j++)
        if (res[j]) begin
          if (words) m |= 128'hFFFF << (16 * j);
          else m |= 128'hFF << (8 * j);
        end
      r.mask_lo = m[63:0];
      r.mask_hi = m[127:64];
    end else begin
      r.mask_lo = {48'd0, res};
    end
    r.cf = res != 0;
    r.zf = lb < n;
    r.sf = la < n;
    r.of = res[0];
    return r;
  endfunction

  task automatic send_word(op_t op);
    in_valid_i     <= 1'b1;
    cmd_i          <= op.cmd;
    control_i      <= op.control;
    a_lo_i         <= op.a_lo;
    a_hi_i         <= op.a_hi;
    b_lo_i         <= op.b_lo;
    b_hi_i         <= op.b_hi;
    len_a_i        <= op.len_a;
    len_b_i        <= op.len_b;
    wide_lengths_i <= op.wide;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(predict_result(op));
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Bias toward small element values so zeros and matches show up often
  function automatic logic [63:0] rand_elems(logic words);
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 3))
      0: v = v & (words ? 64'h0003_0003_0003_0003 : 64'h0303_0303_0303_0303);
      1: v = v & (words ? 64'h800F_800F_800F_800F : 64'h8787_8787_8787_8787);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return rand64();
      2: return {32'($urandom()), 32'h8000_0000};
      3: return 64'($signed(-$urandom_range(0, 20)));
      default: return 64'($urandom_range(0, 20)) |
                      ({$urandom(), 32'd0} & {64{1'($urandom_range(0, 1))}});
    endcase
  endfunction

  function automatic op_t rand_op();
    op_t op;
    op.cmd = 2'($urandom_range(0, 3));
    op.control = 7'($urandom_range(0, 127));
    op.a_lo = rand_elems(op.control[0]);
    op.a_hi = rand_elems(op.control[0]);
    op.b_lo = $urandom_range(0, 3) == 0 ? op.a_lo : rand_elems(op.control[0]);
    op.b_hi = $urandom_range(0, 3) == 0 ? op.a_hi : rand_elems(op.control[0]);
    op.len_a = rand_len();
    op.len_b = rand_len();
    op.wide = 1'($urandom_range(0, 1));
    return op;
  endfunction

  task automatic test_directed();
    op_t op;
    for (int c = 0; c < 4; c++)
      for (int agg = 0; agg < 4; agg++) begin
        op = rand_op();
        op.cmd = 2'(c);
        op.control = {1'(agg % 2), 2'(agg), 2'(c), 1'(c % 2), 1'(agg / 2)};
        if (c == 0) begin
          op.a_lo = '1; op.a_hi = '1; op.b_lo = '0; op.b_hi = '0;
          op.len_a = 64'h8000_0000_0000_0000; op.len_b = 64'h7FFF_FFFF_FFFF_FFFF;
          op.wide = 1'b1;
        end else if (c == 1) begin
          op.len_a = 64'h0000_0001_8000_0000; op.len_b = '0; op.wide = 1'b0;
        end
        send_word(op);
      end
    op.cmd = CmdImpMask; op.control = 7'h7F; op.a_lo = '1; op.a_hi = '1;
    op.b_lo = '1; op.b_hi = '1;
    send_word(op);
    op.cmd = CmdImpIdx; op.control = 7'h00; op.a_lo = '0; op.a_hi = '0;
    send_word(op);
    op.cmd = CmdExpIdx; op.len_a = 64'hFFFF_FFFF_FFFF_FFF0; op.len_b = 64'd3;
    send_word(op);
    op.cmd = CmdExpMask; op.control = 7'h4C; op.len_a = 64'd5; op.len_b = 64'd16;
    send_word(op);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_random(int count);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) == 0) pause_sender();
      end
      burst--;
      send_word(rand_op());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver holds off while words keep arriving so the pipe fills
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 30; k++) send_word(rand_op());
    join
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    hold_off = 1'b0;
    done = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = '0; control_i = '0;
    a_lo_i = '0; a_hi_i = '0; b_lo_i = '0; b_hi_i = '0;
    len_a_i = '0; len_b_i = '0; wide_lengths_i = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    test_backpressure();
    test_random(450);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    done = 1'b1;
  end

  // Receiver stall pattern: quiet stretches alternate with random stalls
  int unsigned rx_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_phase <= 0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (hold_off) out_ready_i <= 1'b0;
      else if (rx_phase[7]) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    cmp_res_t got, exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {mask_lo_o, mask_hi_o, match_index_o, flag_carry_o, flag_zero_o,
             flag_sign_o, flag_overflow_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected word %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk_i);
    while (!done && idle_cycles < StallLimit) @(posedge clk_i);
    if (!done) begin
      $display("Simulation FAILED");
    end else if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
